// File: src/spectral_step_update_core_assert.svh
// assertion macros for the rtl
`ifndef SPECTRAL_STEP_UPDATE_CORE_ASSERT_SVH
`define SPECTRAL_STEP_UPDATE_CORE_ASSERT_SVH

// same-cycle implication, off while in reset
`define SSU_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, also active during reset
`define SSU_ASSERT_NEXT(lbl, ck, ante, cons, msg) \
  lbl: assert property (@(posedge ck) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/ssu_pkg.sv
`default_nettype none

package ssu_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int PROP_FRAC       = 16;
  localparam int PROP_W          = 17;
  localparam int DT_W            = 32;
  localparam int MODE_W          = 3;
  localparam int CFG_IDX_W       = 1;
  localparam int CFG_DATA_W      = 32;
  localparam int NSTAGE          = 6;

  localparam logic [MODE_W-1:0] MODE_DIFF  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_AB1   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_AB2   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_HAB1  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_HAB2  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_BHAB1 = 3'd5;
  localparam logic [MODE_W-1:0] MODE_BHAB2 = 3'd6;

  localparam logic [CFG_IDX_W-1:0] REG_STEP_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 1'b1;

  // prefactors in units of dt/2
  typedef struct packed {
    logic [1:0] cin;
    logic [1:0] cout;
    logic       pout;
    logic       puu;
  } coef_t;

  typedef struct packed {
    logic [NSTAGE-1:0] en;
    coef_t             c_in;
    coef_t             c_s1;
    coef_t             c_s2;
  } ctl_t;

  function automatic coef_t coef_sel(input logic [MODE_W-1:0] mode, input logic first);
    coef_t c;
    c = '0;
    unique case (mode)
      MODE_DIFF:  c = '0;
      MODE_AB1:   c.cout = 2'd2;
      MODE_AB2: begin
        c.cout = 2'd3;
        c.pout = !first;
      end
      MODE_HAB1:  c.cin = 2'd2;
      MODE_HAB2: begin
        c.cin = 2'd3;
        c.puu = !first;
      end
      MODE_BHAB1: begin
        c.cin  = 2'd1;
        c.cout = 2'd1;
      end
      MODE_BHAB2: begin
        c.cin  = first ? 2'd2 : 2'd1;
        c.cout = 2'd2;
        c.pout = !first;
      end
      default:    c = '0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// File: src/ssu_stream_if.sv
`default_nettype none

interface ssu_in_if import ssu_pkg::*; #(
  parameter int VW = VALUE_WIDTH_DEF
);
  logic                 valid;
  logic                 ready;
  logic [PROP_W-1:0]    prop_factor;
  logic signed [VW-1:0] rho_re;
  logic signed [VW-1:0] rho_im;
  logic signed [VW-1:0] nl_re;
  logic signed [VW-1:0] nl_im;
  logic signed [VW-1:0] nlprev_re;
  logic signed [VW-1:0] nlprev_im;
  logic                 first_step;
  logic                 last_in;

  modport source (
    output valid, prop_factor, rho_re, rho_im, nl_re, nl_im, nlprev_re, nlprev_im,
    output first_step, last_in,
    input  ready
  );
  modport sink (
    input  valid, prop_factor, rho_re, rho_im, nl_re, nl_im, nlprev_re, nlprev_im,
    input  first_step, last_in,
    output ready
  );
endinterface

interface ssu_out_if import ssu_pkg::*; #(
  parameter int VW = VALUE_WIDTH_DEF
);
  logic                 valid;
  logic                 ready;
  logic signed [VW-1:0] next_re;
  logic signed [VW-1:0] next_im;
  logic                 saturated;
  logic                 last_out;

  modport source (
    output valid, next_re, next_im, saturated, last_out,
    input  ready
  );
  modport sink (
    input  valid, next_re, next_im, saturated, last_out,
    output ready
  );
endinterface

`default_nettype wire

// File: src/spectral_step_update_core.sv
// channel  | dir | handshake      | word
// in_s     | in  | valid / ready  | factor, density, nonlinear terms, flags
// out_m    | out | valid / ready  | next density, saturated, last_out
// cfg_*    | in  | cfg_we         | step_mode, time_step
//
// one word per cycle sustained while out_m is ready
// pipeline depth set by the factor multiply chain and the split dt product
// reset is synchronous: clears stage valid bits, step_mode and time_step
// a full stage holds while the stage after it is stalled; bubbles close up
`default_nettype none

module spectral_step_update_core import ssu_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  ssu_in_if.sink                     in_s,
  ssu_out_if.source                  out_m,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic signed [VALUE_WIDTH-1:0] VMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic signed [VALUE_WIDTH-1:0] VMIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  logic [MODE_W-1:0] mode_r;
  logic [DT_W-1:0]   dt_r;
  ctl_t              ctl;
  logic              sat_re, sat_im;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_DIFF;
      dt_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_STEP_MODE: mode_r <= cfg_data[MODE_W-1:0];
        REG_TIME_STEP: dt_r   <= cfg_data[DT_W-1:0];
        default: ;
      endcase
    end
  end

  ssu_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_s.valid),
    .mode       (mode_r),
    .first_step (in_s.first_step),
    .last_in    (in_s.last_in),
    .out_ready  (out_m.ready),
    .in_ready   (in_s.ready),
    .out_valid  (out_m.valid),
    .last_out   (out_m.last_out),
    .ctl        (ctl)
  );

  ssu_lane #(.VW(VALUE_WIDTH), .FB(FRAC_BITS)) u_lane_re (
    .clk (clk),
    .ctl (ctl),
    .dt  (dt_r),
    .u   (in_s.prop_factor),
    .rho (in_s.rho_re),
    .nl  (in_s.nl_re),
    .nlp (in_s.nlprev_re),
    .res (out_m.next_re),
    .sat (sat_re)
  );

  ssu_lane #(.VW(VALUE_WIDTH), .FB(FRAC_BITS)) u_lane_im (
    .clk (clk),
    .ctl (ctl),
    .dt  (dt_r),
    .u   (in_s.prop_factor),
    .rho (in_s.rho_im),
    .nl  (in_s.nl_im),
    .nlp (in_s.nlprev_im),
    .res (out_m.next_im),
    .sat (sat_im)
  );

  assign out_m.saturated = sat_re | sat_im;

`include "spectral_step_update_core_assert.svh"

  `SSU_ASSERT_NEXT(a_reset_empty, clk, !rst_n, !out_m.valid, "output valid after reset")
  `SSU_ASSERT_NOW(a_flow_ready, clk, rst_n, out_m.ready, in_s.ready,
                  "input blocked while output drains")
  `SSU_ASSERT_NOW(a_empty_ready, clk, rst_n, !out_m.valid, in_s.ready,
                  "input blocked with empty output")
  `SSU_ASSERT_NOW(a_sat_bound, clk, rst_n, out_m.valid && out_m.saturated,
                  (out_m.next_re == VMAX || out_m.next_re == VMIN ||
                   out_m.next_im == VMAX || out_m.next_im == VMIN),
                  "saturated word without a bound value")

endmodule

`default_nettype wire

// File: src/ssu_ctrl.sv
`default_nettype none

module ssu_ctrl import ssu_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic [MODE_W-1:0] mode,
  input  wire logic              first_step,
  input  wire logic              last_in,
  input  wire logic              out_ready,
  output logic                   in_ready,
  output logic                   out_valid,
  output logic                   last_out,
  output ctl_t                   ctl
);

  logic [NSTAGE-1:0] v_r, v_nxt, en;
  logic [NSTAGE-1:0] last_r, last_nxt;
  coef_t             c_in, c1_r, c2_r;

  // a stage loads when empty or when the one after it moves
  always_comb begin
    en[NSTAGE-1] = !v_r[NSTAGE-1] || out_ready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  always_comb begin
    v_nxt[0]    = en[0] ? in_valid : v_r[0];
    last_nxt[0] = en[0] ? last_in : last_r[0];
    for (int k = 1; k < NSTAGE; k++) begin
      v_nxt[k]    = en[k] ? v_r[k-1] : v_r[k];
      last_nxt[k] = en[k] ? last_r[k-1] : last_r[k];
    end
  end

  assign c_in = coef_sel(mode, first_step);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r <= last_nxt;
    if (en[0]) begin
      c1_r <= c_in;
    end
    if (en[1]) begin
      c2_r <= c1_r;
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[NSTAGE-1];
  assign last_out  = last_r[NSTAGE-1];
  assign ctl       = '{en: en, c_in: c_in, c_s1: c1_r, c_s2: c2_r};

endmodule

`default_nettype wire

// File: src/ssu_lane.sv
`default_nettype none

module ssu_lane import ssu_pkg::*; #(
  parameter int VW = VALUE_WIDTH_DEF,
  parameter int FB = FRAC_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire ctl_t                 ctl,
  input  wire logic [DT_W-1:0]      dt,
  input  wire logic [PROP_W-1:0]    u,
  input  wire logic signed [VW-1:0] rho,
  input  wire logic signed [VW-1:0] nl,
  input  wire logic signed [VW-1:0] nlp,
  output logic signed [VW-1:0]      res,
  output logic                      sat
);

  localparam int MW   = VW + PROP_W;
  localparam int XW   = VW + 3;
  localparam int PPW  = VW + 2 * PROP_W;
  localparam int XDW  = XW + DT_W + 1;
  localparam int NCW  = MW + 2;
  localparam int ZW0  = (NCW + PROP_FRAC > PPW) ? NCW + PROP_FRAC : PPW;
  localparam int ZW   = ZW0 + 1;
  localparam int H    = ZW / 2;
  localparam int HW   = ZW - H;
  localparam int PLW  = H + DT_W;
  localparam int PHW  = HW + DT_W + 1;
  localparam int DROP = 2 * PROP_FRAC + FB + 1;
  localparam int A1W  = MW + PROP_FRAC + FB + 1;
  localparam int A2W  = XDW + 2 * PROP_FRAC;
  localparam int ZDW  = ZW + DT_W + 1;
  localparam int AM1  = (A1W > A2W) ? A1W : A2W;
  localparam int AM2  = (AM1 > ZDW) ? AM1 : ZDW;
  localparam int AW   = AM2 + 2;
  localparam int QW   = AW - DROP;
  localparam logic [AW-1:0] RND = {{(AW-DROP){1'b0}}, 1'b1, {(DROP-1){1'b0}}};
  localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

  logic signed [PROP_W:0]   u_s, u1_s;
  logic signed [DT_W:0]     dt_s;
  logic signed [XW-1:0]     n1, p1;

  logic signed [MW-1:0]     ru_nxt, nu_nxt, pu_nxt, ru_r, nu_r, pu_r, ru2_r;
  logic signed [XW-1:0]     x_nxt, x_r;
  logic [PROP_W-1:0]        u1_r;
  logic signed [PPW-1:0]    ppu_nxt, ppu_r;
  logic signed [XDW-1:0]    xd_nxt, xd_r;
  logic signed [NCW-1:0]    ncin_nxt, ncin_r;
  logic signed [ZW-1:0]     z_nxt, z_r;
  logic signed [AW-1:0]     a_nxt, a_r, a4_r;
  logic [H-1:0]             zl;
  logic signed [HW-1:0]     zh;
  logic [PLW-1:0]           pl_nxt, pl_r;
  logic signed [PHW-1:0]    ph_nxt, ph_r;
  logic signed [AW-1:0]     pl_ext, sum_nxt, sum_r;
  logic signed [QW-1:0]     q;
  logic                     fits;
  logic signed [VW-1:0]     res_nxt, res_r;
  logic                     sat_nxt, sat_r;

  assign u_s  = signed'({1'b0, u});
  assign u1_s = signed'({1'b0, u1_r});
  assign dt_s = signed'({1'b0, dt});

  // stage 1: products with the factor, nonlinear combination outside u
  always_comb begin
    n1     = XW'(nl);
    p1     = XW'(nlp);
    ru_nxt = MW'(rho) * MW'(u_s);
    nu_nxt = MW'(nl) * MW'(u_s);
    pu_nxt = MW'(nlp) * MW'(u_s);
    x_nxt  = (ctl.c_in.cout[1] ? (n1 <<< 1) : XW'(0))
           + (ctl.c_in.cout[0] ? n1 : XW'(0))
           - (ctl.c_in.pout ? p1 : XW'(0));
  end

  // stage 2
  always_comb begin
    ppu_nxt  = PPW'(pu_r) * PPW'(u1_s);
    xd_nxt   = XDW'(x_r) * XDW'(dt_s);
    ncin_nxt = (ctl.c_s1.cin[1] ? (NCW'(nu_r) <<< 1) : NCW'(0))
             + (ctl.c_s1.cin[0] ? NCW'(nu_r) : NCW'(0));
  end

  // stage 3: terms that still need dt, and the aligned partial sum
  always_comb begin
    z_nxt = (ZW'(ncin_r) <<< PROP_FRAC) - (ctl.c_s2.puu ? ZW'(ppu_r) : ZW'(0));
    a_nxt = (AW'(ru2_r) <<< (PROP_FRAC + FB + 1)) + (AW'(xd_r) <<< (2 * PROP_FRAC));
  end

  // stage 4: split product by dt
  always_comb begin
    zl     = z_r[H-1:0];
    zh     = signed'(z_r[ZW-1:H]);
    pl_nxt = PLW'(zl) * PLW'(dt);
    ph_nxt = PHW'(zh) * PHW'(dt_s);
  end

  // stage 5: full sum with rounding half
  always_comb begin
    pl_ext  = AW'(pl_r);
    sum_nxt = a4_r + (AW'(ph_r) <<< H) + pl_ext + signed'(RND);
  end

  // stage 6: drop fraction and clip
  always_comb begin
    q    = signed'(sum_r[AW-1:DROP]);
    fits = (q[QW-1:VW-1] == {(QW-VW+1){q[QW-1]}});
    if (fits) begin
      res_nxt = q[VW-1:0];
      sat_nxt = 1'b0;
    end else begin
      res_nxt = q[QW-1] ? VMIN : VMAX;
      sat_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      ru_r <= ru_nxt;
      nu_r <= nu_nxt;
      pu_r <= pu_nxt;
      x_r  <= x_nxt;
      u1_r <= u;
    end
    if (ctl.en[1]) begin
      ppu_r  <= ppu_nxt;
      xd_r   <= xd_nxt;
      ncin_r <= ncin_nxt;
      ru2_r  <= ru_r;
    end
    if (ctl.en[2]) begin
      z_r <= z_nxt;
      a_r <= a_nxt;
    end
    if (ctl.en[3]) begin
      pl_r <= pl_nxt;
      ph_r <= ph_nxt;
      a4_r <= a_r;
    end
    if (ctl.en[4]) begin
      sum_r <= sum_nxt;
    end
    if (ctl.en[5]) begin
      res_r <= res_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign res = res_r;
  assign sat = sat_r;

endmodule

`default_nettype wire

// File: tb/ssu_tb_pkg.sv
package ssu_tb_pkg;
  import ssu_pkg::*;

  localparam int VW   = VALUE_WIDTH_DEF;
  localparam int FB   = FRAC_BITS_DEF;
  localparam int DROP = 2 * PROP_FRAC + FB + 1;

  // register allows it, no mode defined for it
  localparam logic [MODE_W-1:0] MODE_SPARE = 3'd7;

  localparam logic signed [VW-1:0] VAL_MAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] VAL_MIN = {1'b1, {(VW-1){1'b0}}};

  typedef struct {
    logic [PROP_W-1:0]    prop;
    logic signed [VW-1:0] rho_re;
    logic signed [VW-1:0] rho_im;
    logic signed [VW-1:0] nl_re;
    logic signed [VW-1:0] nl_im;
    logic signed [VW-1:0] nlp_re;
    logic signed [VW-1:0] nlp_im;
    logic                 first;
    logic                 last;
  } coeff_word_t;

  typedef struct {
    logic signed [VW-1:0] next_re;
    logic signed [VW-1:0] next_im;
    logic                 sat;
    logic                 last;
  } density_word_t;

  class density_scoreboard;
    logic [MODE_W-1:0] mode;
    logic [DT_W-1:0]   dt;
    density_word_t     pending_density[$];
    int                errors;
    int                words_in;
    int                words_out;
    int                clipped;

    function new();
      mode      = '0;
      dt        = '0;
      errors    = 0;
      words_in  = 0;
      words_out = 0;
      clipped   = 0;
    endfunction

    function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
      if (idx == REG_STEP_MODE) begin
        mode = data[MODE_W-1:0];
      end else begin
        dt = data[DT_W-1:0];
      end
    endfunction

    function int outstanding();
      return pending_density.size();
    endfunction

    // weights in units of dt/2: n inside u, n outside u, np outside, np under u*u
    function void step_weights(input logic first, output int unsigned cin,
                               output int unsigned cout, output int unsigned pout,
                               output int unsigned puu);
      cin  = 0;
      cout = 0;
      pout = 0;
      puu  = 0;
      case (mode)
        MODE_AB1: begin
          cout = 2;
        end
        MODE_AB2: begin
          cout = 3;
          pout = first ? 0 : 1;
        end
        MODE_HAB1: begin
          cin = 2;
        end
        MODE_HAB2: begin
          cin = 3;
          puu = first ? 0 : 1;
        end
        MODE_BHAB1: begin
          cin  = 1;
          cout = 1;
        end
        MODE_BHAB2: begin
          cin  = first ? 2 : 1;
          cout = 2;
          pout = first ? 0 : 1;
        end
        default: begin
        end
      endcase
    endfunction

    // exact update in a wide accumulator, one rounding, then clip
    function logic signed [VW-1:0] next_density(input logic signed [VW-1:0] rho,
                                                input logic signed [VW-1:0] nl,
                                                input logic signed [VW-1:0] nlp,
                                                input logic [PROP_W-1:0] u,
                                                input logic first, output logic clip);
      logic signed [127:0] acc, wr, wn, wp, uu, dd, kin, kout, kp, kuu, lim_hi, lim_lo;
      int unsigned cin, cout, pout, puu;
      step_weights(first, cin, cout, pout, puu);
      wr   = rho;
      wn   = nl;
      wp   = nlp;
      uu   = u;
      dd   = dt;
      kin  = cin;
      kout = cout;
      kp   = pout;
      kuu  = puu;
      acc  = (wr * uu) <<< (PROP_FRAC + FB + 1);
      acc  = acc + ((wn * uu * (kin * dd)) <<< PROP_FRAC);
      acc  = acc + ((wn * (kout * dd)) <<< (2 * PROP_FRAC));
      acc  = acc - ((wp * (kp * dd)) <<< (2 * PROP_FRAC));
      acc  = acc - (wp * uu * uu * (kuu * dd));
      acc  = acc + (128'sd1 <<< (DROP - 1));
      acc  = acc >>> DROP;
      lim_hi = (128'sd1 <<< (VW - 1)) - 128'sd1;
      lim_lo = -(128'sd1 <<< (VW - 1));
      clip = 1'b1;
      if (acc > lim_hi) begin
        return VAL_MAX;
      end else if (acc < lim_lo) begin
        return VAL_MIN;
      end
      clip = 1'b0;
      return acc[VW-1:0];
    endfunction

    function void note_input(input coeff_word_t w);
      density_word_t d;
      logic clip_re, clip_im;
      d.next_re = next_density(w.rho_re, w.nl_re, w.nlp_re, w.prop, w.first, clip_re);
      d.next_im = next_density(w.rho_im, w.nl_im, w.nlp_im, w.prop, w.first, clip_im);
      d.sat     = clip_re | clip_im;
      d.last    = w.last;
      if (d.sat) clipped++;
      words_in++;
      pending_density.push_back(d);
    endfunction

    function void check_result(input density_word_t got);
      density_word_t want;
      words_out++;
      if (pending_density.size() == 0) begin
        $error("unexpected result word: next_re %0d next_im %0d", got.next_re, got.next_im);
        errors++;
        return;
      end
      want = pending_density.pop_front();
      if (got.next_re !== want.next_re) begin
        $error("next_re: expected %0d, got %0d", want.next_re, got.next_re);
        errors++;
      end
      if (got.next_im !== want.next_im) begin
        $error("next_im: expected %0d, got %0d", want.next_im, got.next_im);
        errors++;
      end
      if (got.sat !== want.sat) begin
        $error("saturated: expected %0b, got %0b", want.sat, got.sat);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last_out: expected %0b, got %0b", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

endpackage

// File: tb/tb_spectral_step_update_core.sv
module tb_spectral_step_update_core;
  timeunit 1ns;
  timeprecision 1ps;

  import ssu_pkg::*;
  import ssu_tb_pkg::*;

  localparam int PHASES      = 16;
  localparam int PHASE_WORDS = 120;
  localparam int DRAIN_LIMIT = 20000;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  bit                    calm;
  int                    settings_run;

  density_scoreboard sb;

  ssu_in_if  in_ch ();
  ssu_out_if out_ch ();

  spectral_step_update_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_s     (in_ch),
    .out_m    (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  initial begin
    #4_800_000;
    $display("tb_spectral_step_update_core: FAIL");
    $finish;
  end

  always @(posedge clk) begin
    out_ch.ready <= calm || ($urandom_range(99) >= 14);
  end

  always @(posedge clk) begin : watch_out
    density_word_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.next_re = out_ch.next_re;
      got.next_im = out_ch.next_im;
      got.sat     = out_ch.saturated;
      got.last    = out_ch.last_out;
      sb.check_result(got);
    end
  end

  task automatic send_word(input coeff_word_t w);
    while (!calm && $urandom_range(99) < 14) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.prop_factor <= w.prop;
    in_ch.rho_re      <= w.rho_re;
    in_ch.rho_im      <= w.rho_im;
    in_ch.nl_re       <= w.nl_re;
    in_ch.nl_im       <= w.nl_im;
    in_ch.nlprev_re   <= w.nlp_re;
    in_ch.nlprev_im   <= w.nlp_im;
    in_ch.first_step  <= w.first;
    in_ch.last_in     <= w.last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_input(w);
  endtask

  task automatic wait_drain();
    int waited;
    waited = 0;
    in_ch.valid <= 1'b0;
    do begin
      @(posedge clk);
      waited++;
    end while (sb.outstanding() != 0 && waited < DRAIN_LIMIT);
  endtask

  task automatic load_settings(input logic [MODE_W-1:0] m, input logic [DT_W-1:0] d);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_STEP_MODE;
    cfg_data <= CFG_DATA_W'(m);
    @(posedge clk);
    sb.set_reg(REG_STEP_MODE, CFG_DATA_W'(m));
    cfg_idx  <= REG_TIME_STEP;
    cfg_data <= d;
    @(posedge clk);
    sb.set_reg(REG_TIME_STEP, d);
    cfg_we <= 1'b0;
    settings_run++;
  endtask

  function automatic logic signed [VW-1:0] rand_value();
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel < 3) return $urandom;
    if (sel < 6) return int'($urandom_range(32'h0080_0000)) - 32'sh0040_0000;
    if (sel < 8) return int'($urandom_range(32'h0002_0000)) - 32'sh0001_0000;
    case ($urandom_range(5))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2: return VAL_MAX - int'($urandom_range(255));
      3: return VAL_MIN + int'($urandom_range(255));
      4: return '0;
      default: return '1;
    endcase
  endfunction

  function automatic coeff_word_t rand_word();
    coeff_word_t w;
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 75) w.prop = PROP_W'($urandom_range(32'h1_0000));
    else if (sel < 85) w.prop = PROP_W'(32'h1_0000);
    else if (sel < 90) w.prop = '0;
    else w.prop = PROP_W'($urandom_range(32'h1_0001, 32'h1_FFFF));
    w.rho_re = rand_value();
    w.rho_im = rand_value();
    w.nl_re  = rand_value();
    w.nl_im  = rand_value();
    w.nlp_re = rand_value();
    w.nlp_im = rand_value();
    w.first  = ($urandom_range(3) == 0);
    w.last   = ($urandom_range(15) == 0);
    return w;
  endfunction

  initial begin
    coeff_word_t       w;
    logic [MODE_W-1:0] m;
    logic [DT_W-1:0]   d;
    sb             = new();
    settings_run   = 0;
    calm           = 1'b0;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = '0;
    cfg_data       = '0;
    in_ch.valid       = 1'b0;
    in_ch.prop_factor = '0;
    in_ch.rho_re      = '0;
    in_ch.rho_im      = '0;
    in_ch.nl_re       = '0;
    in_ch.nl_im       = '0;
    in_ch.nlprev_re   = '0;
    in_ch.nlprev_im   = '0;
    in_ch.first_step  = 1'b0;
    in_ch.last_in     = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every mode with extreme words, with and without a previous term
    for (int i = 0; i < 8; i++) begin
      m = MODE_W'(i);
      d = m[0] ? '1 : 32'h0000_8000;
      load_settings(m, d);
      w = '{prop: PROP_W'(32'h1_0000), rho_re: VAL_MAX, rho_im: VAL_MIN,
            nl_re: 32'sh0001_0000, nl_im: -32'sh0001_0000,
            nlp_re: -32'sh0001_0000, nlp_im: 32'sh0001_0000, first: 1'b0, last: 1'b0};
      send_word(w);
      w = '{prop: '1, rho_re: VAL_MIN, rho_im: VAL_MAX, nl_re: VAL_MAX, nl_im: VAL_MIN,
            nlp_re: VAL_MIN, nlp_im: VAL_MAX, first: 1'b1, last: 1'b1};
      send_word(w);
      w = '{prop: PROP_W'(32'h0_8000), rho_re: 32'sh0001_0000, rho_im: -32'sh0001_0000,
            nl_re: 32'sh0000_8000, nl_im: -32'sh1, nlp_re: 32'sh3, nlp_im: '0,
            first: 1'b0, last: 1'b1};
      send_word(w);
      wait_drain();
    end

    for (int p = 0; p < PHASES; p++) begin
      if (p < 7) m = MODE_W'(p);
      else if ($urandom_range(7) == 0) m = MODE_SPARE;
      else m = MODE_W'($urandom_range(int'(MODE_BHAB2)));
      case ((p >> 1) % 4)
        0: d = '0;
        1: d = '1;
        2: d = DT_W'($urandom_range(32'h0004_0000));
        default: d = $urandom;
      endcase
      calm = (p == 9 || p == 10);
      load_settings(m, d);
      for (int k = 0; k < PHASE_WORDS; k++) begin
        send_word(rand_word());
        // hold the sender until the pipe is empty
        if (p == 4 && k == 60) wait_drain();
      end
      wait_drain();
    end
    calm = 1'b0;

    repeat (NSTAGE + 4) @(posedge clk);
    if (sb.outstanding() != 0) begin
      $error("%0d result words never arrived", sb.outstanding());
      sb.errors++;
    end
    $display("run covered %0d words over %0d mode/time-step settings, all modes",
             sb.words_in, settings_run);
    $display("%0d results checked, %0d expected clipped, %0d mismatches",
             sb.words_out, sb.clipped, sb.errors);
    if (sb.errors == 0) begin
      $display("tb_spectral_step_update_core: PASS");
    end else begin
      $display("tb_spectral_step_update_core: FAIL");
    end
    $finish;
  end

endmodule
